[rtl/spa_pkg.sv]
// Types and constants shared by the sparse polynomial adder.
`timescale 1ns / 1ps
package spa_pkg;

  localparam int COEF_W      = 16;
  localparam int EXPON_W     = 8;
  localparam int ACTION_W    = 2;
  localparam int MAX_RESULTS = 32;
  localparam int RES_W       = 6;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD_A = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_START  = 2'd2,
    ACT_IGNORE = 2'd3
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic [EXPON_W-1:0]       expon;
  } term_t;

  localparam int TERM_W = $bits(term_t);

  typedef struct packed {
    logic  take_a;
    logic  take_b;
    logic  emit;
    logic  done;
    term_t term;
  } step_t;

endpackage

[rtl/spa_if.sv]
// Valid/ready channel interfaces for input words and result words.
`timescale 1ns / 1ps
interface spa_in_if;
  import spa_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [ACTION_W-1:0]      action;
  logic signed [COEF_W-1:0] coef_in;
  logic [EXPON_W-1:0]       expon_in;

  modport source (output valid, action, coef_in, expon_in, input ready);
  modport sink (input valid, action, coef_in, expon_in, output ready);
endinterface

interface spa_out_if;
  import spa_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] coef_out;
  logic [EXPON_W-1:0]       expon_out;
  logic                     last_term;
  logic                     empty_sum;
  logic                     overflowed;

  modport source (output valid, coef_out, expon_out, last_term, empty_sum, overflowed,
                  input ready);
  modport sink (input valid, coef_out, expon_out, last_term, empty_sum, overflowed,
                output ready);
endinterface

[rtl/spa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module spa_ram #(
  parameter int WIDTH  = 24,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/spa_merge_unit.sv]
// Compare and saturating-add unit that decides one merge step.
`timescale 1ns / 1ps
module spa_merge_unit (
  input  spa_pkg::term_t a_term,
  input  spa_pkg::term_t b_term,
  input  logic           a_avail,
  input  logic           b_avail,
  output spa_pkg::step_t step
);
  import spa_pkg::*;

  logic signed [COEF_W:0]   sum;
  logic signed [COEF_W-1:0] sat;

  always_comb begin
    sum = {a_term.coef[COEF_W-1], a_term.coef} + {b_term.coef[COEF_W-1], b_term.coef};
    if (sum[COEF_W] != sum[COEF_W-1]) begin
      sat = sum[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end else begin
      sat = sum[COEF_W-1:0];
    end
  end

  always_comb begin
    step = '0;
    priority if (a_avail && b_avail) begin
      if (a_term.expon > b_term.expon) begin
        step.take_a = 1'b1;
        step.emit   = 1'b1;
        step.term   = a_term;
      end else if (a_term.expon < b_term.expon) begin
        step.take_b = 1'b1;
        step.emit   = 1'b1;
        step.term   = b_term;
      end else begin
        step.take_a     = 1'b1;
        step.take_b     = 1'b1;
        step.emit       = (sat != '0);
        step.term.coef  = sat;
        step.term.expon = a_term.expon;
      end
    end else if (a_avail) begin
      step.take_a = 1'b1;
      step.emit   = 1'b1;
      step.term   = a_term;
    end else if (b_avail) begin
      step.take_b = 1'b1;
      step.emit   = 1'b1;
      step.term   = b_term;
    end else begin
      step.done = 1'b1;
    end
  end

endmodule

[rtl/sparse_polynomial_add_core.sv]
// Sparse polynomial adder: term stores, merge sequencer and result register.
//
// Input words arrive on in_word: action 0 appends a term to store A, action 1
// appends one to store B, action 2 starts the merge and action 3 is ignored.
// Loads give no result; a load into a full store is dropped and remembered for
// the overflowed flag. While a merge runs, in_word.ready is low. The merge
// walks both stores with one compare and add unit, one step per cycle unless
// the output stalls; a step takes the term with the larger exponent or a pair
// of terms with equal exponents. Each result word passes through a holding
// register and then the output register before it reaches out_word; it waits
// in the holding register until the next term or the end of the merge shows
// whether it is the final one. The final word carries last_term, and an empty
// sum gives a single word with empty_sum set. Both stores are emptied when the
// merge finishes.
// When the receiver holds out_word.ready low, the merge pauses only when a word
// has to move into a full output register, and resumes without loss.
// Reset is synchronous and active low; it empties both stores, clears the
// overflow flag and drops any result word in flight.
`timescale 1ns / 1ps
module sparse_polynomial_add_core #(
  parameter int TERMS = 16
) (
  input logic      clk,
  input logic      rst_n,
  spa_in_if.sink   in_word,
  spa_out_if.source out_word
);
  import spa_pkg::*;

  localparam int AW = (TERMS > 1) ? $clog2(TERMS) : 1;
  localparam int CW = $clog2(TERMS + 1);

  state_t         state_r, state_nxt;
  logic [CW-1:0]  a_cnt_r, a_cnt_nxt, b_cnt_r, b_cnt_nxt;
  logic [CW-1:0]  ia_r, ia_nxt, ib_r, ib_nxt;
  logic [RES_W-1:0] n_r, n_nxt;
  logic           ovf_r, ovf_nxt;
  logic           hold_valid_r, hold_valid_nxt;
  term_t          hold_r, hold_nxt;
  logic           out_valid_r, out_valid_nxt;
  term_t          out_term_r, out_term_nxt;
  logic           out_last_r, out_last_nxt;
  logic           out_empty_r, out_empty_nxt;
  logic           out_ovf_r, out_ovf_nxt;

  logic           accept, can_push, push, need_push;
  logic           a_we, b_we;
  term_t          load_term, a_rd, b_rd;
  step_t          step;
  logic           a_avail, b_avail;

  assign accept    = in_word.valid && in_word.ready;
  assign load_term = '{coef: in_word.coef_in, expon: in_word.expon_in};
  assign can_push  = !out_valid_r || out_word.ready;
  assign a_avail   = (ia_r < a_cnt_r) && (n_r < RES_W'(MAX_RESULTS));
  assign b_avail   = (ib_r < b_cnt_r) && (n_r < RES_W'(MAX_RESULTS));
  assign need_push = (step.emit && hold_valid_r) || step.done;

  spa_ram #(.WIDTH(TERM_W), .DEPTH(TERMS), .ADDR_W(AW)) u_store_a (
    .clk  (clk),
    .we   (a_we),
    .waddr(a_cnt_r[AW-1:0]),
    .wdata(load_term),
    .raddr(ia_nxt[AW-1:0]),
    .rdata(a_rd)
  );

  spa_ram #(.WIDTH(TERM_W), .DEPTH(TERMS), .ADDR_W(AW)) u_store_b (
    .clk  (clk),
    .we   (b_we),
    .waddr(b_cnt_r[AW-1:0]),
    .wdata(load_term),
    .raddr(ib_nxt[AW-1:0]),
    .rdata(b_rd)
  );

  spa_merge_unit u_merge (
    .a_term (a_rd),
    .b_term (b_rd),
    .a_avail(a_avail),
    .b_avail(b_avail),
    .step   (step)
  );

  always_comb begin
    state_nxt      = state_r;
    a_cnt_nxt      = a_cnt_r;
    b_cnt_nxt      = b_cnt_r;
    ia_nxt         = ia_r;
    ib_nxt         = ib_r;
    n_nxt          = n_r;
    ovf_nxt        = ovf_r;
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    a_we           = 1'b0;
    b_we           = 1'b0;
    push           = 1'b0;
    out_term_nxt   = hold_r;
    out_last_nxt   = 1'b0;
    out_empty_nxt  = 1'b0;
    out_ovf_nxt    = 1'b0;
    in_word.ready  = (state_r == ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (action_t'(in_word.action))
            ACT_LOAD_A: begin
              if (a_cnt_r < CW'(TERMS)) begin
                a_we      = 1'b1;
                a_cnt_nxt = a_cnt_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            ACT_LOAD_B: begin
              if (b_cnt_r < CW'(TERMS)) begin
                b_we      = 1'b1;
                b_cnt_nxt = b_cnt_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            ACT_START: begin
              ia_nxt         = '0;
              ib_nxt         = '0;
              n_nxt          = '0;
              hold_valid_nxt = 1'b0;
              state_nxt      = ST_MERGE;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MERGE: begin
        if (!need_push || can_push) begin
          ia_nxt = ia_r + CW'(step.take_a);
          ib_nxt = ib_r + CW'(step.take_b);
          push   = need_push;
          if (step.emit) begin
            hold_nxt       = step.term;
            hold_valid_nxt = 1'b1;
            n_nxt          = n_r + RES_W'(1);
          end
          if (step.done) begin
            out_last_nxt   = 1'b1;
            out_empty_nxt  = !hold_valid_r;
            out_ovf_nxt    = ovf_r;
            if (!hold_valid_r) begin
              out_term_nxt = '0;
            end
            hold_valid_nxt = 1'b0;
            a_cnt_nxt      = '0;
            b_cnt_nxt      = '0;
            ovf_nxt        = 1'b0;
            state_nxt      = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_word.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      a_cnt_r      <= '0;
      b_cnt_r      <= '0;
      ia_r         <= '0;
      ib_r         <= '0;
      n_r          <= '0;
      ovf_r        <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      a_cnt_r      <= a_cnt_nxt;
      b_cnt_r      <= b_cnt_nxt;
      ia_r         <= ia_nxt;
      ib_r         <= ib_nxt;
      n_r          <= n_nxt;
      ovf_r        <= ovf_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    if (push) begin
      out_term_r  <= out_term_nxt;
      out_last_r  <= out_last_nxt;
      out_empty_r <= out_empty_nxt;
      out_ovf_r   <= out_ovf_nxt;
    end
  end

  assign out_word.valid      = out_valid_r;
  assign out_word.coef_out   = out_term_r.coef;
  assign out_word.expon_out  = out_term_r.expon;
  assign out_word.last_term  = out_last_r;
  assign out_word.empty_sum  = out_empty_r;
  assign out_word.overflowed = out_ovf_r;

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the sparse polynomial adder core: random and directed term loads.
`timescale 1ns / 1ps
module tb_top;
  import spa_pkg::*;

  localparam int TERMS = 16;
  localparam int ITEMS = 500;
  localparam int CALM_ITEMS = 60;

  typedef struct {
    action_t                  act;
    logic signed [COEF_W-1:0] coef;
    logic [EXPON_W-1:0]       expon;
    bit                       hold;
    bit                       jitter;
  } send_word_t;

  typedef struct {
    logic signed [COEF_W-1:0] coef;
    logic [EXPON_W-1:0]       expon;
    bit                       last_term;
    bit                       empty_sum;
    bit                       overflowed;
  } sum_term_t;

  logic clk;
  logic rst_n;

  spa_in_if  in_if();
  spa_out_if out_if();

  sparse_polynomial_add_core #(.TERMS(TERMS)) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_if),
    .out_word(out_if)
  );

  send_word_t send_q[$];
  sum_term_t  want_terms[$];
  sum_term_t  want;

  logic signed [COEF_W-1:0] poly_a_coef[TERMS];
  logic [EXPON_W-1:0]       poly_a_expon[TERMS];
  logic signed [COEF_W-1:0] poly_b_coef[TERMS];
  logic [EXPON_W-1:0]       poly_b_expon[TERMS];
  int                       poly_a_len = 0;
  int                       poly_b_len = 0;
  bit                       dropped_load = 0;

  int  miss_count = 0;
  int  words_queued = 0;
  int  words_taken = 0;
  int  items_planned = 0;
  int  merges_run = 0;
  int  terms_seen = 0;
  int  sat_sums = 0;
  int  empty_sums = 0;
  int  full_merges = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  bit  jitter_on = 1;
  bit  rx_jitter = 0;

  task automatic report_miss(input string msg);
    miss_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic add_sum_term(input logic signed [COEF_W-1:0] coef,
                              input logic [EXPON_W-1:0] expon, inout sum_term_t run[$]);
    sum_term_t t;
    t.coef = coef;
    t.expon = expon;
    t.last_term = 0;
    t.empty_sum = 0;
    t.overflowed = 0;
    run.push_back(t);
  endtask

  task automatic apply_word(input action_t act, input logic signed [COEF_W-1:0] coef,
                            input logic [EXPON_W-1:0] expon);
    sum_term_t run[$];
    int        ia;
    int        ib;
    int        s;
    ia = 0;
    ib = 0;
    case (act)
      ACT_LOAD_A: begin
        if (poly_a_len < TERMS) begin
          poly_a_coef[poly_a_len] = coef;
          poly_a_expon[poly_a_len] = expon;
          poly_a_len++;
        end else begin
          dropped_load = 1;
        end
      end
      ACT_LOAD_B: begin
        if (poly_b_len < TERMS) begin
          poly_b_coef[poly_b_len] = coef;
          poly_b_expon[poly_b_len] = expon;
          poly_b_len++;
        end else begin
          dropped_load = 1;
        end
      end
      ACT_START: begin
        while (ia < poly_a_len && ib < poly_b_len) begin
          if (poly_a_expon[ia] > poly_b_expon[ib]) begin
            add_sum_term(poly_a_coef[ia], poly_a_expon[ia], run);
            ia++;
          end else if (poly_a_expon[ia] < poly_b_expon[ib]) begin
            add_sum_term(poly_b_coef[ib], poly_b_expon[ib], run);
            ib++;
          end else begin
            s = int'(poly_a_coef[ia]) + int'(poly_b_coef[ib]);
            if (s > 32767 || s < -32768) sat_sums++;
            if (s > 32767) s = 32767;
            if (s < -32768) s = -32768;
            if (s != 0) add_sum_term(s[COEF_W-1:0], poly_a_expon[ia], run);
            ia++;
            ib++;
          end
        end
        for (; ia < poly_a_len; ia++) add_sum_term(poly_a_coef[ia], poly_a_expon[ia], run);
        for (; ib < poly_b_len; ib++) add_sum_term(poly_b_coef[ib], poly_b_expon[ib], run);
        if (run.size() == 0) begin
          add_sum_term('0, '0, run);
          run[0].empty_sum = 1;
          empty_sums++;
        end
        run[run.size()-1].last_term = 1;
        run[run.size()-1].overflowed = dropped_load;
        if (dropped_load) full_merges++;
        foreach (run[i]) want_terms.push_back(run[i]);
        merges_run++;
        poly_a_len = 0;
        poly_b_len = 0;
        dropped_load = 0;
      end
      default: begin
      end
    endcase
  endtask

  function automatic logic signed [COEF_W-1:0] pick_coef();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 16'sh7fff;
      2: return 16'sh8000;
      default: return r[COEF_W-1:0];
    endcase
  endfunction

  task automatic push_word(input action_t act, input logic signed [COEF_W-1:0] coef,
                           input logic [EXPON_W-1:0] expon);
    send_word_t w;
    w.act = act;
    w.coef = coef;
    w.expon = expon;
    w.hold = 0;
    w.jitter = jitter_on;
    send_q.push_back(w);
    words_queued++;
  endtask

  task automatic queue_word(input action_t act, input logic signed [COEF_W-1:0] coef,
                            input logic [EXPON_W-1:0] expon);
    if ($urandom_range(0, 24) == 0)
      push_word(ACT_IGNORE, pick_coef(), EXPON_W'($urandom_range(0, 255)));
    push_word(act, coef, expon);
    items_planned++;
  endtask

  task automatic queue_hold();
    send_word_t w;
    w.act = ACT_IGNORE;
    w.coef = '0;
    w.expon = '0;
    w.hold = 1;
    w.jitter = jitter_on;
    send_q.push_back(w);
  endtask

  task automatic queue_sum(input int na, input int nb, input bit tidy);
    logic signed [COEF_W-1:0] ac[$];
    logic signed [COEF_W-1:0] bc[$];
    logic [EXPON_W-1:0]       ae[$];
    logic [EXPON_W-1:0]       be[$];
    logic signed [COEF_W-1:0] c;
    int                       e;
    int                       pick;
    int                       ka;
    int                       kb;
    if (tidy) begin
      e = $urandom_range(255, 100);
      while ((ae.size() < na || be.size() < nb) && e >= 0) begin
        pick = $urandom_range(0, 2);
        if (ae.size() >= na) pick = 1;
        if (be.size() >= nb) pick = 0;
        c = pick_coef();
        if (pick != 1) begin
          ac.push_back(c);
          ae.push_back(e[EXPON_W-1:0]);
        end
        if (pick != 0) begin
          case ($urandom_range(0, 3))
            0: bc.push_back(-c);
            1: bc.push_back(c);
            default: bc.push_back(pick_coef());
          endcase
          be.push_back(e[EXPON_W-1:0]);
        end
        e -= $urandom_range(1, 3);
      end
    end else begin
      for (int i = 0; i < na; i++) begin
        ac.push_back(pick_coef());
        ae.push_back(EXPON_W'($urandom_range(0, 255)));
      end
      for (int i = 0; i < nb; i++) begin
        bc.push_back(pick_coef());
        be.push_back(EXPON_W'($urandom_range(0, 255)));
      end
    end
    ka = 0;
    kb = 0;
    while (ka < ac.size() || kb < bc.size()) begin
      if (kb >= bc.size() || (ka < ac.size() && $urandom_range(0, 1) == 1)) begin
        queue_word(ACT_LOAD_A, ac[ka], ae[ka]);
        ka++;
      end else begin
        queue_word(ACT_LOAD_B, bc[kb], be[kb]);
        kb++;
      end
    end
    queue_word(ACT_START, pick_coef(), EXPON_W'($urandom_range(0, 255)));
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.action = ACT_IGNORE;
    in_if.coef_in = '0;
    in_if.expon_in = '0;
    out_if.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #400000;
    $display("FAIL sparse_polynomial_add_core");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        apply_word(action_t'(in_if.action), in_if.coef_in, in_if.expon_in);
        words_taken++;
        rx_jitter <= send_q[0].jitter;
        if (send_q[0].jitter && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 16);
        void'(send_q.pop_front());
      end
      if (in_if.valid && !in_if.ready) begin
      end else if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (send_q.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (send_q[0].hold) begin
        in_if.valid <= 1'b0;
        if (want_terms.size() == 0) void'(send_q.pop_front());
      end else begin
        in_if.valid <= 1'b1;
        in_if.action <= send_q[0].act;
        in_if.coef_in <= send_q[0].coef;
        in_if.expon_in <= send_q[0].expon;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (want_terms.size() == 0) begin
          report_miss($sformatf("result word with nothing pending, expon_out %0d",
                                out_if.expon_out));
        end else begin
          want = want_terms.pop_front();
          terms_seen++;
          if (out_if.coef_out !== want.coef)
            report_miss($sformatf("coef_out %0d, want %0d (expon %0d)",
                                  out_if.coef_out, want.coef, want.expon));
          if (out_if.expon_out !== want.expon)
            report_miss($sformatf("expon_out %0d, want %0d", out_if.expon_out, want.expon));
          if (out_if.last_term !== want.last_term)
            report_miss($sformatf("last_term %b, want %b (expon %0d)",
                                  out_if.last_term, want.last_term, want.expon));
          if (out_if.empty_sum !== want.empty_sum)
            report_miss($sformatf("empty_sum %b, want %b", out_if.empty_sum, want.empty_sum));
          if (out_if.overflowed !== want.overflowed)
            report_miss($sformatf("overflowed %b, want %b",
                                  out_if.overflowed, want.overflowed));
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (rx_jitter && $urandom_range(0, 11) == 0) recv_gap = $urandom_range(1, 16);
      end
    end
  end

  initial begin
    queue_word(ACT_START, '0, '0);
    queue_word(ACT_LOAD_A, 16'sh7fff, 8'd255);
    queue_word(ACT_LOAD_A, 16'sh8000, 8'd0);
    queue_word(ACT_LOAD_B, 16'sh7fff, 8'd255);
    queue_word(ACT_LOAD_B, 16'sh8000, 8'd0);
    queue_word(ACT_START, '0, '0);
    queue_word(ACT_LOAD_A, 16'sd256, 8'd10);
    queue_word(ACT_LOAD_A, 16'sd0, 8'd5);
    queue_word(ACT_LOAD_B, -16'sd256, 8'd10);
    queue_word(ACT_START, 16'shffff, 8'hff);
    push_word(ACT_IGNORE, 16'shffff, 8'hff);
    queue_word(ACT_LOAD_A, 16'sd1, 8'd3);
    queue_word(ACT_LOAD_A, 16'sd2, 8'd7);
    queue_word(ACT_LOAD_B, 16'sd3, 8'd5);
    queue_word(ACT_START, '0, '0);
    queue_word(ACT_LOAD_A, 16'sh1234, 8'd200);
    queue_word(ACT_START, '0, '0);
    queue_word(ACT_LOAD_B, -16'sd5, 8'd1);
    queue_word(ACT_START, '0, '0);
    queue_word(ACT_LOAD_A, 16'sd128, 8'd9);
    queue_word(ACT_LOAD_B, -16'sd128, 8'd9);
    queue_word(ACT_START, '0, '0);
    queue_hold();

    while (items_planned < ITEMS) begin
      jitter_on = (items_planned < ITEMS - CALM_ITEMS) ? ($urandom_range(0, 3) != 0) : 1'b0;
      case ($urandom_range(0, 9))
        0, 1: queue_sum($urandom_range(0, 20), $urandom_range(0, 20), 1'b0);
        2: queue_sum($urandom_range(10, 16), $urandom_range(10, 16), 1'b1);
        default: queue_sum($urandom_range(0, 6), $urandom_range(0, 6), 1'b1);
      endcase
      if ($urandom_range(0, 9) == 0) queue_hold();
    end

    while (words_taken < words_queued) @(posedge clk);
    while (want_terms.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d input words through %0d merges, checked %0d result terms.",
             words_taken, merges_run, terms_seen);
    $display("Saturated sums: %0d, empty sums: %0d, merges after a dropped load: %0d.",
             sat_sums, empty_sums, full_merges);
    if (miss_count == 0) begin
      $display("PASS sparse_polynomial_add_core");
    end else begin
      $display("FAIL sparse_polynomial_add_core");
    end
    $finish;
  end

endmodule
